@@ src/eiku_pkg.sv @@
package eiku_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W       = 12;
  localparam int unsigned DIM_W         = 13;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned MAX_GRID_DIM  = 4096;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_GRID_DIM);

  // Control handed to the root pipeline
  typedef struct packed {
    logic advance;
    logic valid;
  } eiku_ctl_t;

endpackage

@@ src/eikonal_upwind_update_2d_core.sv @@
// First-order upwind update of one grid point for a 2-D fast-marching
// eikonal solver.
// Input channel: in_valid_i / in_ready_o carry one beat per grid point:
// col, row, the point's own time, its four neighbor times and the squared
// cost p2, all times unsigned fixed point with 16 fraction bits.
// Output channel: out_valid_o / out_ready_i carry one beat per input beat,
// in order: the new time (saturated to all-ones) and the two-sided flag.
// Config port: cfg_we_i writes cfg_data_i into grid_width (index 0) or
// grid_height (index 1); values above the maximum grid size are clamped.
// Write it only while no beat is in flight.
// Pipeline: 5 + ROOT_W register stages, 30 at the default 32-bit values.
// ROOT_W = (VALUE_BITS + 18) / 2 stages of the bit-per-stage square root
// pipeline set that figure.
// Throughput: one beat per cycle while the output is not stalled.
// A stall at the output freezes every stage and holds in_ready_o low;
// no beat is dropped or repeated.
// Reset clears all valid bits and sets both grid dimensions to the maximum.
module eikonal_upwind_update_2d_core
  import eiku_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DIM_W-1:0]      cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_W-1:0]    col_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic [VALUE_BITS-1:0] u_center_i,
  input  logic [VALUE_BITS-1:0] u_left_i,
  input  logic [VALUE_BITS-1:0] u_right_i,
  input  logic [VALUE_BITS-1:0] u_up_i,
  input  logic [VALUE_BITS-1:0] u_down_i,
  input  logic [VALUE_BITS-1:0] p2_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] new_u_o,
  output logic                  two_sided_o
);

  localparam int unsigned V      = VALUE_BITS;
  localparam int unsigned PS_W   = V + FRAC_BITS;          // p2 scaled by 2^FRAC
  localparam int unsigned DD_W   = 2 * V;                  // d squared
  localparam int unsigned ROOT_W = (PS_W + 2) / 2;         // root of 2*ps
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned DIFF_W = (DD_W + 1 > RAD_W) ? DD_W + 1 : RAD_W;
  localparam int unsigned SIDE_W = 2 * V + 2;
  localparam int unsigned SUM_W  = ((V > ROOT_W) ? V : ROOT_W) + 2;

  localparam logic [V-1:0] VMASK = '1;

  // Global advance: move every stage unless the output holds a beat
  // that the receiver has not taken.
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  //--------------------------------------------------------------------------
  // Grid dimension registers
  //--------------------------------------------------------------------------
  logic [DIM_W-1:0] grid_w_q, grid_h_q;
  logic [DIM_W-1:0] cfg_clamped;

  assign cfg_clamped = (cfg_data_i > DIM_MAX) ? DIM_MAX : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= DIM_MAX;
      grid_h_q <= DIM_MAX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GRID_WIDTH:  grid_w_q <= cfg_clamped;
        REG_GRID_HEIGHT: grid_h_q <= cfg_clamped;
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // Stage 1: substitute out-of-grid neighbors, take per-axis minima
  //--------------------------------------------------------------------------
  logic [DIM_W-1:0] col_x, row_x;
  logic             out_l, out_r, out_u, out_d;
  logic [V-1:0]     ul, ur, uu, ud;
  logic [V-1:0]     s1_mx_d, s1_my_d;
  logic             s1_valid_q;
  logic [V-1:0]     s1_mx_q, s1_my_q, s1_p_q;

  assign col_x = {1'b0, col_i};
  assign row_x = {1'b0, row_i};

  assign out_l = (col_i == '0) || ((col_x - DIM_W'(1)) >= grid_w_q);
  assign out_r = (col_x + DIM_W'(1)) >= grid_w_q;
  assign out_u = (row_i == '0) || ((row_x - DIM_W'(1)) >= grid_h_q);
  assign out_d = (row_x + DIM_W'(1)) >= grid_h_q;

  assign ul = out_l ? u_center_i : u_left_i;
  assign ur = out_r ? u_center_i : u_right_i;
  assign uu = out_u ? u_center_i : u_up_i;
  assign ud = out_d ? u_center_i : u_down_i;

  assign s1_mx_d = (ul < ur) ? ul : ur;
  assign s1_my_d = (uu < ud) ? uu : ud;

  //--------------------------------------------------------------------------
  // Stage 2: order the minima into A (larger) and B (smaller), d = A - B
  //--------------------------------------------------------------------------
  logic             s2_valid_q;
  logic [V-1:0]     s2_a_q, s2_b_q, s2_d_q, s2_p_q;
  logic [V-1:0]     s2_a_d, s2_b_d;

  assign s2_a_d = (s1_mx_q > s1_my_q) ? s1_mx_q : s1_my_q;
  assign s2_b_d = (s1_mx_q > s1_my_q) ? s1_my_q : s1_mx_q;

  //--------------------------------------------------------------------------
  // Stage 3: square d, scale p2, flag infinite operands
  //--------------------------------------------------------------------------
  logic             s3_valid_q;
  logic [V-1:0]     s3_a_q, s3_b_q;
  logic [DD_W-1:0]  s3_dd_q;
  logic [PS_W-1:0]  s3_ps_q;
  logic             s3_ainf_q, s3_binf_q;
  logic [DD_W-1:0]  s3_dd_d;

  assign s3_dd_d = {{V{1'b0}}, s2_d_q} * {{V{1'b0}}, s2_d_q};

  //--------------------------------------------------------------------------
  // Stage 4: pick the formula and its radicand
  //--------------------------------------------------------------------------
  logic              s4_valid_q;
  logic [RAD_W-1:0]  s4_rad_q;
  logic [V-1:0]      s4_a_q, s4_b_q;
  logic              s4_two_q, s4_binf_q;
  logic [DIFF_W-1:0] ps_ext, dd_ext, diff;
  logic              s4_two_d;
  logic [RAD_W-1:0]  s4_rad_d;

  assign ps_ext   = {{(DIFF_W-PS_W){1'b0}}, s3_ps_q};
  assign dd_ext   = {{(DIFF_W-DD_W){1'b0}}, s3_dd_q};
  assign diff     = {ps_ext[DIFF_W-2:0], 1'b0} - dd_ext;
  // Two-sided root exceeds A exactly when P > d^2
  assign s4_two_d = !s3_ainf_q && !s3_binf_q && (ps_ext > dd_ext);
  assign s4_rad_d = s4_two_d ? diff[RAD_W-1:0]
                             : {{(RAD_W-PS_W){1'b0}}, s3_ps_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mx_q   <= s1_mx_d;
      s1_my_q   <= s1_my_d;
      s1_p_q    <= p2_i;

      s2_a_q    <= s2_a_d;
      s2_b_q    <= s2_b_d;
      s2_d_q    <= s2_a_d - s2_b_d;
      s2_p_q    <= s1_p_q;

      s3_a_q    <= s2_a_q;
      s3_b_q    <= s2_b_q;
      s3_dd_q   <= s3_dd_d;
      s3_ps_q   <= {s2_p_q, {FRAC_BITS{1'b0}}};
      s3_ainf_q <= (s2_a_q == VMASK);
      s3_binf_q <= (s2_b_q == VMASK) || (s2_p_q == VMASK);

      s4_rad_q  <= s4_rad_d;
      s4_a_q    <= s3_a_q;
      s4_b_q    <= s3_b_q;
      s4_two_q  <= s4_two_d;
      s4_binf_q <= s3_binf_q;
    end
  end

  //--------------------------------------------------------------------------
  // Square root pipeline, one root bit per stage
  //--------------------------------------------------------------------------
  eiku_ctl_t         sq_ctl;
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_side;

  assign sq_ctl.advance = adv;
  assign sq_ctl.valid   = s4_valid_q;

  eiku_isqrt #(
    .ROOT_W (ROOT_W),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sq_ctl),
    .rad_i   (s4_rad_q),
    .side_i  ({s4_a_q, s4_b_q, s4_two_q, s4_binf_q}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  //--------------------------------------------------------------------------
  // Final sum, halving, saturation and output register
  //--------------------------------------------------------------------------
  logic [V-1:0]     f_a, f_b;
  logic             f_two, f_binf;
  logic [SUM_W-1:0] a_x, b_x, s_x, sum2, res;
  logic             sat;
  logic [V-1:0]     new_u_d;

  assign {f_a, f_b, f_two, f_binf} = sq_side;

  assign a_x  = SUM_W'(f_a);
  assign b_x  = SUM_W'(f_b);
  assign s_x  = SUM_W'(sq_root);
  assign sum2 = a_x + b_x + s_x;
  assign res  = f_two ? {1'b0, sum2[SUM_W-1:1]} : (b_x + s_x);
  assign sat  = f_binf || (res > SUM_W'(VMASK));

  assign new_u_d = sat ? VMASK : res[V-1:0];

  logic             out_valid_q;
  logic [V-1:0]     new_u_q;
  logic             two_sided_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      new_u_q     <= new_u_d;
      two_sided_q <= f_two;
    end
  end

  assign out_valid_o = out_valid_q;
  assign new_u_o     = new_u_q;
  assign two_sided_o = two_sided_q;

endmodule

@@ src/eiku_isqrt.sv @@
module eiku_isqrt
  import eiku_pkg::*;
#(
  parameter int unsigned ROOT_W = 25,
  parameter int unsigned SIDE_W = 66
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  eiku_ctl_t             ctl_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned RAD_W = 2 * ROOT_W;
  localparam int unsigned TRY_W = ROOT_W + 2;

  // One root bit per stage; remainder stays below 2^ROOT_W until the last stage
  logic [ROOT_W-1:0] vld_q;
  logic [ROOT_W-1:0] rem_q  [ROOT_W-1];
  logic [RAD_W-1:0]  rad_q  [ROOT_W-1];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vld_in;
    logic [ROOT_W-1:0] rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [TRY_W-1:0]  rem_sh;
    logic [TRY_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_in  = ctl_i.valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctl_i.advance) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.advance) begin
        root_q[k] <= {root_in[ROOT_W-2:0], take};
        side_q[k] <= side_in;
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      logic [TRY_W-1:0] rem_nx;
      assign rem_nx = take ? (rem_sh - trial) : rem_sh;
      always_ff @(posedge clk_i) begin
        if (ctl_i.advance) begin
          rem_q[k] <= rem_nx[ROOT_W-1:0];
          rad_q[k] <= {rad_in[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule
